>>> rtl/fbpa_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the fixed block pool allocator.
package fbpa_pkg;

   localparam int ADDR_W        = 32;
   localparam int BLOCK_SIZE_W  = 16;
   localparam int STATUS_W      = 2;
   localparam int DIV_STEPS     = 32;
   localparam int DIV_STEP_W    = $clog2(DIV_STEPS);
   localparam int QUEUE_DEPTH   = 2;
   localparam int QUEUE_PTR_W   = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_LEVEL_W = $clog2(QUEUE_DEPTH + 1);

   // register interface
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic CSR_REG_BASE_ADDRESS = 1'b0;
   localparam logic CSR_REG_BLOCK_SIZE   = 1'b1;
   localparam logic [ADDR_W-1:0]       BASE_ADDRESS_RESET = 32'd0;
   localparam logic [BLOCK_SIZE_W-1:0] BLOCK_SIZE_RESET   = 16'd16;

   // request kinds
   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   // result status codes
   localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY    = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_BAD_FREE = 2'd2;

   typedef enum logic [1:0] {
      CMD_ALLOC,
      CMD_FREE,
      CMD_BAD
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type      kind;
      logic [ADDR_W-1:0] offset;
   } cmd_type;

   typedef struct packed {
      logic [ADDR_W-1:0]       base_address;
      logic [BLOCK_SIZE_W-1:0] block_size;
   } cfg_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_READ,
      BK_SUM,
      BK_DIV,
      BK_CHECK,
      BK_RESULT
   } back_state_type;

endpackage

>>> rtl/fbpa_ram.sv
`timescale 1ns / 1ps
// Generic single-port RAM with registered read data.
module fbpa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                                      clock,
   input  logic                                      we,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] addr,
   input  logic [WIDTH-1:0]                          wdata,
   output logic [WIDTH-1:0]                          rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;

endmodule

>>> rtl/fbpa_div.sv
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle.
module fbpa_div (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic [fbpa_pkg::ADDR_W-1:0]         dividend,
   input  logic [fbpa_pkg::BLOCK_SIZE_W-1:0]   divisor,
   output logic                                done,
   output logic [fbpa_pkg::ADDR_W-1:0]         quotient
);

   localparam int RW = fbpa_pkg::BLOCK_SIZE_W;

   logic                                busy_ff, busy_in;
   logic                                done_ff, done_in;
   logic [fbpa_pkg::DIV_STEP_W-1:0]     step_ff, step_in;
   logic [RW-1:0]                       rem_ff, rem_in;
   logic [fbpa_pkg::ADDR_W-1:0]         quo_ff, quo_in;
   logic [RW:0]                         trial;
   logic [RW:0]                         diff;

   always_comb begin
      trial   = {rem_ff, quo_ff[fbpa_pkg::ADDR_W-1]};
      diff    = trial - {1'b0, divisor};
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = fbpa_pkg::DIV_STEP_W'(fbpa_pkg::DIV_STEPS - 1);
         rem_in  = '0;
         quo_in  = dividend;
      end else if (busy_ff) begin
         // remainder stays below the divisor, so the top trial bit drops out
         if (trial >= {1'b0, divisor}) begin
            rem_in = diff[RW-1:0];
            quo_in = {quo_ff[fbpa_pkg::ADDR_W-2:0], 1'b1};
         end else begin
            rem_in = trial[RW-1:0];
            quo_in = {quo_ff[fbpa_pkg::ADDR_W-2:0], 1'b0};
         end
         step_in = step_ff - 1'b1;
         if (step_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      step_ff <= step_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff))
      else $error("divider finished without running");

endmodule

>>> rtl/fbpa_front.sv
`timescale 1ns / 1ps
// Request front end: classifies requests and queues them for the back end.
module fbpa_front (
   input  logic                          clock,
   input  logic                          reset,
   input  fbpa_pkg::cfg_type             cfg,
   input  logic                          push,
   output logic                          full,
   input  logic                          req_op,
   input  logic [fbpa_pkg::ADDR_W-1:0]   req_address,
   output logic                          cmd_valid,
   output fbpa_pkg::cmd_type             cmd,
   input  logic                          cmd_take
);

   fbpa_pkg::cmd_type                     queue_ff [fbpa_pkg::QUEUE_DEPTH];
   fbpa_pkg::cmd_type                     new_cmd;
   logic [fbpa_pkg::QUEUE_PTR_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [fbpa_pkg::QUEUE_PTR_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [fbpa_pkg::QUEUE_LEVEL_W-1:0]    level_ff, level_in;
   logic                                  wr_en;
   logic                                  rd_en;

   always_comb begin
      new_cmd.offset = req_address - cfg.base_address;
      if (req_op == fbpa_pkg::OP_ALLOC) begin
         new_cmd.kind = fbpa_pkg::CMD_ALLOC;
      end else if (req_address < cfg.base_address || cfg.block_size == '0) begin
         new_cmd.kind = fbpa_pkg::CMD_BAD;
      end else begin
         new_cmd.kind = fbpa_pkg::CMD_FREE;
      end
   end

   assign full      = (level_ff == fbpa_pkg::QUEUE_LEVEL_W'(fbpa_pkg::QUEUE_DEPTH));
   assign cmd_valid = (level_ff != '0);
   assign cmd       = queue_ff[rd_ptr_ff];
   assign wr_en     = push && !full;
   assign rd_en     = cmd_take && cmd_valid;

   always_comb begin
      wr_ptr_in = wr_en ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = rd_en ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      level_in  = level_ff;
      if (wr_en && !rd_en) begin
         level_in = level_ff + 1'b1;
      end else if (rd_en && !wr_en) begin
         level_in = level_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
      if (wr_en) begin
         queue_ff[wr_ptr_ff] <= new_cmd;
      end
   end

   a_level_bound: assert property (@(posedge clock) disable iff (reset)
      level_ff <= fbpa_pkg::QUEUE_LEVEL_W'(fbpa_pkg::QUEUE_DEPTH))
      else $error("request queue overfilled");

endmodule

>>> rtl/fbpa_back.sv
`timescale 1ns / 1ps
// Back end: free slot stack, address arithmetic and result register.
module fbpa_back #(
   parameter int SLOTS = 256
) (
   input  logic                              clock,
   input  logic                              reset,
   input  fbpa_pkg::cfg_type                 cfg,
   input  logic                              cmd_valid,
   input  fbpa_pkg::cmd_type                 cmd,
   output logic                              cmd_take,
   output logic                              empty,
   input  logic                              pop,
   output logic [fbpa_pkg::ADDR_W-1:0]       rsp_block_address,
   output logic [fbpa_pkg::STATUS_W-1:0]     rsp_status
);

   localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CNT_W  = $clog2(SLOTS + 1);
   localparam int PROD_W = fbpa_pkg::BLOCK_SIZE_W + SLOT_W;

   fbpa_pkg::back_state_type               state_ff, state_in;
   logic [CNT_W-1:0]                       count_ff, count_in;
   // lowest count reached since reset: entries below it are unwritten since reset and read as their index
   logic [CNT_W-1:0]                       mark_ff, mark_in;
   logic [CNT_W-1:0]                       pop_idx;
   logic                                   bypass_ff, bypass_in;
   logic [SLOT_W-1:0]                      idx_ff, idx_in;
   logic [SLOT_W-1:0]                      slot;
   logic [PROD_W-1:0]                      prod_ff, prod_in;
   logic [fbpa_pkg::ADDR_W-1:0]            res_addr_ff, res_addr_in;
   logic [fbpa_pkg::STATUS_W-1:0]          res_status_ff, res_status_in;
   logic                                   out_valid_ff, out_valid_in;
   logic [fbpa_pkg::ADDR_W-1:0]            out_addr_ff, out_addr_in;
   logic [fbpa_pkg::STATUS_W-1:0]          out_status_ff, out_status_in;

   logic                                   ram_we;
   logic [SLOT_W-1:0]                      ram_addr;
   logic [SLOT_W-1:0]                      ram_wdata;
   logic [SLOT_W-1:0]                      ram_rdata;
   logic                                   div_start;
   logic                                   div_done;
   logic [fbpa_pkg::ADDR_W-1:0]            quotient;

   fbpa_ram #(
      .WIDTH (SLOT_W),
      .DEPTH (SLOTS)
   ) u_stack (
      .clock (clock),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
   );

   fbpa_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (cmd.offset),
      .divisor  (cfg.block_size),
      .done     (div_done),
      .quotient (quotient)
   );

   assign pop_idx = count_ff - 1'b1;
   assign slot    = bypass_ff ? idx_ff : ram_rdata;

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      mark_in       = mark_ff;
      bypass_in     = bypass_ff;
      idx_in        = idx_ff;
      prod_in       = prod_ff;
      res_addr_in   = res_addr_ff;
      res_status_in = res_status_ff;
      out_valid_in  = out_valid_ff && !pop;
      out_addr_in   = out_addr_ff;
      out_status_in = out_status_ff;
      ram_we        = 1'b0;
      ram_addr      = pop_idx[SLOT_W-1:0];
      ram_wdata     = quotient[SLOT_W-1:0];
      cmd_take      = 1'b0;
      div_start     = 1'b0;
      unique case (state_ff)
         fbpa_pkg::BK_IDLE: begin
            if (cmd_valid) begin
               cmd_take = 1'b1;
               case (cmd.kind)
                  fbpa_pkg::CMD_ALLOC: begin
                     if (count_ff == '0) begin
                        res_addr_in   = '0;
                        res_status_in = fbpa_pkg::STATUS_EMPTY;
                        state_in      = fbpa_pkg::BK_RESULT;
                     end else begin
                        count_in  = pop_idx;
                        idx_in    = pop_idx[SLOT_W-1:0];
                        bypass_in = (pop_idx < mark_ff);
                        if (pop_idx < mark_ff) begin
                           mark_in = pop_idx;
                        end
                        state_in = fbpa_pkg::BK_READ;
                     end
                  end
                  fbpa_pkg::CMD_FREE: begin
                     div_start = 1'b1;
                     state_in  = fbpa_pkg::BK_DIV;
                  end
                  default: begin
                     res_addr_in   = '0;
                     res_status_in = fbpa_pkg::STATUS_BAD_FREE;
                     state_in      = fbpa_pkg::BK_RESULT;
                  end
               endcase
            end
         end
         fbpa_pkg::BK_READ: begin
            prod_in  = PROD_W'(cfg.block_size) * PROD_W'(slot);
            state_in = fbpa_pkg::BK_SUM;
         end
         fbpa_pkg::BK_SUM: begin
            res_addr_in   = cfg.base_address + fbpa_pkg::ADDR_W'(prod_ff);
            res_status_in = fbpa_pkg::STATUS_OK;
            state_in      = fbpa_pkg::BK_RESULT;
         end
         fbpa_pkg::BK_DIV: begin
            if (div_done) begin
               state_in = fbpa_pkg::BK_CHECK;
            end
         end
         fbpa_pkg::BK_CHECK: begin
            res_addr_in = '0;
            if (quotient >= fbpa_pkg::ADDR_W'(SLOTS) || count_ff >= CNT_W'(SLOTS)) begin
               res_status_in = fbpa_pkg::STATUS_BAD_FREE;
            end else begin
               ram_we        = 1'b1;
               ram_addr      = count_ff[SLOT_W-1:0];
               count_in      = count_ff + 1'b1;
               res_status_in = fbpa_pkg::STATUS_OK;
            end
            state_in = fbpa_pkg::BK_RESULT;
         end
         fbpa_pkg::BK_RESULT: begin
            if (!out_valid_ff || pop) begin
               out_valid_in  = 1'b1;
               out_addr_in   = res_addr_ff;
               out_status_in = res_status_ff;
               state_in      = fbpa_pkg::BK_IDLE;
            end
         end
         default: begin
            state_in = fbpa_pkg::BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= fbpa_pkg::BK_IDLE;
         count_ff     <= CNT_W'(SLOTS);
         mark_ff      <= CNT_W'(SLOTS);
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         mark_ff      <= mark_in;
         out_valid_ff <= out_valid_in;
      end
      bypass_ff     <= bypass_in;
      idx_ff        <= idx_in;
      prod_ff       <= prod_in;
      res_addr_ff   <= res_addr_in;
      res_status_ff <= res_status_in;
      out_addr_ff   <= out_addr_in;
      out_status_ff <= out_status_in;
   end

   assign empty             = !out_valid_ff;
   assign rsp_block_address = out_addr_ff;
   assign rsp_status        = out_status_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(SLOTS))
      else $error("free count beyond pool size");

   a_mark_below_count: assert property (@(posedge clock) disable iff (reset)
      mark_ff <= count_ff)
      else $error("fill mark above free count");

   a_push_has_room: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> (count_ff < CNT_W'(SLOTS)) && (quotient < fbpa_pkg::ADDR_W'(SLOTS)))
      else $error("slot pushed onto full stack or out of range");

endmodule

>>> rtl/fixed_block_pool_allocator.sv
`timescale 1ns / 1ps
// Top level of the fixed block pool allocator: register port, front and back ends.
//
//  channel   ports                                   transfer when
//  request   push full req_op req_address            push && !full
//  result    empty pop rsp_block_address rsp_status  pop && !empty
//  register  psel penable pwrite paddr pwdata ...    psel && penable && pwrite
//
// Allocate: the back end steps through stack read, multiply, add and result (result only if empty).
// Free: 32-step divider, bounds check, result; bad frees go straight to the result.
// One request in the back end at a time; a two-entry queue takes new requests meanwhile.
// Synchronous reset restores all slots free at once; no clearing pass.
// A waiting result stalls only the back end; requests queue up until full.
module fixed_block_pool_allocator #(
   parameter int SLOTS = 256
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 push,
   output logic                                 full,
   input  logic                                 req_op,
   input  logic [31:0]                          req_address,
   output logic                                 empty,
   input  logic                                 pop,
   output logic [31:0]                          rsp_block_address,
   output logic [1:0]                           rsp_status,
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [fbpa_pkg::CSR_ADDR_W-1:0]      paddr,
   input  logic [fbpa_pkg::CSR_DATA_W-1:0]      pwdata,
   output logic [fbpa_pkg::CSR_DATA_W-1:0]      prdata,
   output logic                                 pready
);

   fbpa_pkg::cfg_type   cfg_ff, cfg_in;
   fbpa_pkg::cmd_type   cmd;
   logic                cmd_valid;
   logic                cmd_take;
   logic                csr_write;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (paddr[2])
            fbpa_pkg::CSR_REG_BASE_ADDRESS:
               cfg_in.base_address = pwdata;
            fbpa_pkg::CSR_REG_BLOCK_SIZE:
               cfg_in.block_size = pwdata[fbpa_pkg::BLOCK_SIZE_W-1:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[2])
         fbpa_pkg::CSR_REG_BASE_ADDRESS:
            prdata = cfg_ff.base_address;
         fbpa_pkg::CSR_REG_BLOCK_SIZE:
            prdata = fbpa_pkg::CSR_DATA_W'(cfg_ff.block_size);
         default: prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.base_address <= fbpa_pkg::BASE_ADDRESS_RESET;
         cfg_ff.block_size   <= fbpa_pkg::BLOCK_SIZE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   fbpa_front u_front (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .push        (push),
      .full        (full),
      .req_op      (req_op),
      .req_address (req_address),
      .cmd_valid   (cmd_valid),
      .cmd         (cmd),
      .cmd_take    (cmd_take)
   );

   fbpa_back #(
      .SLOTS (SLOTS)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg_ff),
      .cmd_valid         (cmd_valid),
      .cmd               (cmd),
      .cmd_take          (cmd_take),
      .empty             (empty),
      .pop               (pop),
      .rsp_block_address (rsp_block_address),
      .rsp_status        (rsp_status)
   );

endmodule

>>> tb/sv/fixed_block_pool_allocator_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for the fixed block pool allocator: directed cases, then random traffic.
module fixed_block_pool_allocator_test;

   localparam int POOL_SLOTS   = 256;
   localparam int STALL_LIMIT  = 2000;
   localparam int SETTLE_WAIT  = 8;
   localparam int DRAIN_CYCLES = 48;
   localparam int MAX_PRINTED  = 100;
   localparam logic [fbpa_pkg::CSR_ADDR_W-1:0] BASE_REG_ADDR =
      {fbpa_pkg::CSR_REG_BASE_ADDRESS, 2'b00};
   localparam logic [fbpa_pkg::CSR_ADDR_W-1:0] BLOCK_SIZE_REG_ADDR =
      {fbpa_pkg::CSR_REG_BLOCK_SIZE, 2'b00};

   typedef struct packed {
      logic [fbpa_pkg::ADDR_W-1:0]   block_address;
      logic [fbpa_pkg::STATUS_W-1:0] status;
   } pool_result_type;

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            push = 1'b0;
   logic                            full;
   logic                            req_op = fbpa_pkg::OP_ALLOC;
   logic [31:0]                     req_address = '0;
   logic                            empty;
   logic                            pop = 1'b0;
   logic [31:0]                     rsp_block_address;
   logic [1:0]                      rsp_status;
   logic                            psel = 1'b0;
   logic                            penable = 1'b0;
   logic                            pwrite = 1'b0;
   logic [fbpa_pkg::CSR_ADDR_W-1:0] paddr = '0;
   logic [fbpa_pkg::CSR_DATA_W-1:0] pwdata = '0;
   logic [fbpa_pkg::CSR_DATA_W-1:0] prdata;
   logic                            pready;

   // allocator mirror
   logic [fbpa_pkg::ADDR_W-1:0]       cfg_base;
   logic [fbpa_pkg::BLOCK_SIZE_W-1:0] cfg_block_size;
   logic [7:0]                        slot_stack [POOL_SLOTS];
   logic [8:0]                        free_slots;
   logic [7:0]                        held_slots [$];

   pool_result_type pending_results [$];
   pool_result_type head_result;
   int              mismatch_count = 0;
   int              stall_cycles = 0;
   bit              stalls_on = 1'b1;

   fixed_block_pool_allocator #(
      .SLOTS(POOL_SLOTS)
   ) u_dut (
      .clock(clock),
      .reset(reset),
      .push(push),
      .full(full),
      .req_op(req_op),
      .req_address(req_address),
      .empty(empty),
      .pop(pop),
      .rsp_block_address(rsp_block_address),
      .rsp_status(rsp_status),
      .psel(psel),
      .penable(penable),
      .pwrite(pwrite),
      .paddr(paddr),
      .pwdata(pwdata),
      .prdata(prdata),
      .pready(pready)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   task automatic report_mismatch(input string msg);
      if (mismatch_count < MAX_PRINTED)
         $display("%0t ns: %s", $time, msg);
      mismatch_count++;
   endtask

   function automatic pool_result_type predict_request(input logic op, input logic [31:0] addr);
      pool_result_type res;
      logic [31:0]     slot;
      res.block_address = '0;
      res.status = fbpa_pkg::STATUS_OK;
      if (op == fbpa_pkg::OP_ALLOC) begin
         if (free_slots == 0) begin
            res.status = fbpa_pkg::STATUS_EMPTY;
         end else begin
            free_slots--;
            res.block_address = cfg_base + 32'(cfg_block_size) * 32'(slot_stack[free_slots]);
            held_slots.insert(held_slots.size(), slot_stack[free_slots]);
         end
      end else if (addr < cfg_base || cfg_block_size == 0 || free_slots >= POOL_SLOTS) begin
         res.status = fbpa_pkg::STATUS_BAD_FREE;
      end else begin
         slot = (addr - cfg_base) / 32'(cfg_block_size);
         if (slot >= POOL_SLOTS) begin
            res.status = fbpa_pkg::STATUS_BAD_FREE;
         end else begin
            slot_stack[free_slots] = slot[7:0];
            free_slots++;
         end
      end
      return res;
   endfunction

   // push stays high between back-to-back requests; it is lowered only for a gap or while waiting for idle
   task automatic send_request(input logic op, input logic [31:0] addr);
      pool_result_type predicted;
      while (stalls_on && $urandom_range(99) < 25) begin
         push <= 1'b0;
         @(posedge clock);
      end
      push <= 1'b1;
      req_op <= op;
      req_address <= addr;
      @(posedge clock);
      while (full !== 1'b0)
         @(posedge clock);
      predicted = predict_request(op, addr);
      pending_results.insert(pending_results.size(), predicted);
   endtask

   task automatic wait_until_idle();
      push <= 1'b0;
      while (pending_results.size() != 0)
         @(posedge clock);
      repeat (SETTLE_WAIT) @(posedge clock);
   endtask

   task automatic csr_write(input logic [fbpa_pkg::CSR_ADDR_W-1:0] addr,
                            input logic [31:0] data);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= addr;
      pwdata <= data;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (pready !== 1'b1)
         @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_config(input logic [31:0] base, input logic [15:0] block_size);
      wait_until_idle();
      csr_write(BASE_REG_ADDR, base);
      cfg_base = base;
      csr_write(BLOCK_SIZE_REG_ADDR, {16'h0000, block_size});
      cfg_block_size = block_size;
   endtask

   // allocates at the given percentage; frees are mostly of blocks actually handed out, the rest stray addresses
   task automatic random_request(input int alloc_pct);
      int          idx;
      int          kind;
      logic [7:0]  slot;
      logic [31:0] addr;
      if ($urandom_range(99) < alloc_pct) begin
         send_request(fbpa_pkg::OP_ALLOC, $urandom());
      end else begin
         kind = $urandom_range(9);
         if (kind < 7 && held_slots.size() != 0) begin
            idx = $urandom_range(held_slots.size() - 1);
            slot = held_slots[idx];
            held_slots.delete(idx);
            addr = cfg_base + 32'(cfg_block_size) * 32'(slot);
            if (cfg_block_size > 1)
               addr = addr + $urandom_range(cfg_block_size - 1);
         end else begin
            case (kind % 3)
               0: addr = $urandom();
               1: addr = (cfg_base == 0) ? $urandom() : $urandom_range(cfg_base - 1);
               default: addr = cfg_base + 32'(cfg_block_size) * POOL_SLOTS + $urandom_range(15);
            endcase
         end
         send_request(fbpa_pkg::OP_FREE, addr);
      end
   endtask

   task automatic run_random_items(input int count);
      int alloc_pct;
      alloc_pct = 50;
      for (int i = 0; i < count; i++) begin
         if (i % 32 == 0) begin
            case ($urandom_range(2))
               0: alloc_pct = 85;
               1: alloc_pct = 50;
               default: alloc_pct = 15;
            endcase
         end
         random_request(alloc_pct);
      end
   endtask

   task automatic test_reset_state();
      send_request(fbpa_pkg::OP_FREE, 32'h0000_0000);   // stack still full
      send_request(fbpa_pkg::OP_ALLOC, 32'hFFFF_FFFF);
      send_request(fbpa_pkg::OP_ALLOC, 32'h0000_0000);
      send_request(fbpa_pkg::OP_ALLOC, $urandom());
      send_request(fbpa_pkg::OP_FREE, 32'h0000_0FF7);   // inside the top block
      send_request(fbpa_pkg::OP_FREE, 32'h0000_0FF0);   // same block again
      send_request(fbpa_pkg::OP_FREE, 32'h0000_1000);   // just past the pool
      send_request(fbpa_pkg::OP_FREE, 32'hFFFF_FFFF);
      send_request(fbpa_pkg::OP_ALLOC, $urandom());
   endtask

   task automatic test_zero_block_size();
      set_config(32'hA5A5_0000, 16'd0);
      send_request(fbpa_pkg::OP_ALLOC, $urandom());
      send_request(fbpa_pkg::OP_FREE, 32'hA5A5_0000);
      send_request(fbpa_pkg::OP_FREE, 32'hFFFF_FFFF);
   endtask

   task automatic test_address_wrap();
      set_config(32'hFFFF_FFFF, 16'hFFFF);
      send_request(fbpa_pkg::OP_ALLOC, $urandom());
      send_request(fbpa_pkg::OP_FREE, 32'h0000_0000);   // below base
      send_request(fbpa_pkg::OP_FREE, 32'hFFFF_FFFF);
   endtask

   task automatic test_free_bounds();
      set_config(32'h0000_1000, 16'd1);
      send_request(fbpa_pkg::OP_FREE, 32'h0000_0FFF);
      send_request(fbpa_pkg::OP_FREE, 32'h0000_10FF);
      send_request(fbpa_pkg::OP_FREE, 32'h0000_1100);
      send_request(fbpa_pkg::OP_ALLOC, $urandom());
      send_request(fbpa_pkg::OP_ALLOC, $urandom());
   endtask

   task automatic test_pool_exhaustion();
      set_config(32'h0000_4000, 16'd64);
      while (free_slots != 0)
         send_request(fbpa_pkg::OP_ALLOC, $urandom());
      repeat (3) send_request(fbpa_pkg::OP_ALLOC, $urandom());
      repeat (6) random_request(0);
   endtask

   task automatic test_back_to_back();
      stalls_on = 1'b0;
      set_config(32'h0001_0000, 16'd32);
      run_random_items(150);
      wait_until_idle();
      stalls_on = 1'b1;
   endtask

   task automatic test_random_traffic();
      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: set_config(32'h0000_0000, 16'd16);
            1: set_config($urandom(), 16'd1);
            2: set_config(32'h8000_0000, 16'd4096);
            3: set_config(32'hFFFF_0000, 16'hFFFF);
            4: set_config($urandom_range(32'h00FF_FFFF), 16'($urandom_range(65535, 1)));
            default: set_config(32'hFFFF_FFFF, 16'd1);
         endcase
         run_random_items(220);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         pop <= 1'b0;
      end else begin
         if (pop && !empty) begin
            if (pending_results.size() == 0) begin
               report_mismatch($sformatf("result with nothing outstanding: address %h status %0d",
                                         rsp_block_address, rsp_status));
            end else begin
               head_result = pending_results.pop_front();
               if (rsp_block_address !== head_result.block_address)
                  report_mismatch($sformatf("block_address %h, predicted %h",
                                            rsp_block_address, head_result.block_address));
               if (rsp_status !== head_result.status)
                  report_mismatch($sformatf("status %0d, predicted %0d",
                                            rsp_status, head_result.status));
            end
         end
         pop <= stalls_on ? ($urandom_range(99) >= 25) : 1'b1;
      end
   end

   // a run that stops making transfers is a failure
   always @(posedge clock) begin
      if ((push && !full) || (pop && !empty) || (psel && penable && pwrite && pready))
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("fixed_block_pool_allocator: mismatch");
         $finish;
      end
   end

   initial begin
      cfg_base = fbpa_pkg::BASE_ADDRESS_RESET;
      cfg_block_size = fbpa_pkg::BLOCK_SIZE_RESET;
      for (int i = 0; i < POOL_SLOTS; i++)
         slot_stack[i] = 8'(i);
      free_slots = 9'(POOL_SLOTS);
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      test_reset_state();
      test_zero_block_size();
      test_address_wrap();
      test_free_bounds();
      test_pool_exhaustion();
      test_back_to_back();
      test_random_traffic();
      push <= 1'b0;
      while (pending_results.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("fixed_block_pool_allocator: match");
      else
         $display("fixed_block_pool_allocator: mismatch");
      $finish;
   end

endmodule
